FILE: src/lobm_pkg.sv
// shared types and constants for the limit order book matcher
package lobm_pkg;

	localparam int unsigned BOOK_DEPTH_DEF = 16;
	localparam int unsigned TRADER_W = 8;
	localparam int unsigned QTY_W = 24;
	localparam int unsigned PRICE_W = 16;

	typedef struct packed {
		logic [TRADER_W-1:0] trader;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] qty;
	} book_entry_t;

	typedef struct packed {
		logic pop;
		logic dec;
		logic ins;
		logic [QTY_W-1:0] amt;
		book_entry_t ins_entry;
	} book_cmd_t;

	typedef struct packed {
		logic [TRADER_W-1:0] trader;
		logic side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0] qty;
	} rpt_entry_t;

	typedef struct packed {
		logic clr;
		logic ins;
		logic pop;
		rpt_entry_t entry;
	} rpt_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_REP_AGG,
		S_REP_CTR,
		S_REST,
		S_EMIT
	} state_t;

endpackage

FILE: src/lobm_if.sv
// order and report channel interfaces
interface lobm_ord_if;
	logic valid;
	logic ready;
	logic [7:0] trader;
	logic side;
	logic [23:0] quantity;
	logic [15:0] price;
	modport source (output valid, trader, side, quantity, price, input ready);
	modport sink (input valid, trader, side, quantity, price, output ready);
endinterface

interface lobm_rpt_if;
	logic valid;
	logic ready;
	logic [7:0] trader_res;
	logic side_res;
	logic [23:0] quantity_res;
	logic [15:0] price_res;
	logic status;
	logic last;
	modport source (output valid, trader_res, side_res, quantity_res, price_res, status, last,
		input ready);
	modport sink (input valid, trader_res, side_res, quantity_res, price_res, status, last,
		output ready);
endinterface

FILE: src/lobm_book.sv
// one side of the book: sorted shift register with head update and ordered insert
module lobm_book #(
	parameter int unsigned DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic desc,
	input lobm_pkg::book_cmd_t cmd,
	output lobm_pkg::book_entry_t head,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic full
);
	import lobm_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	book_entry_t ent_q [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [DEPTH-1:0] keep;

	// entries that stay ahead of a new order of equal or better price
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			keep[k] = (CW'(k) < cnt_q) &&
				(desc ? (ent_q[k].price >= cmd.ins_entry.price)
				      : (ent_q[k].price <= cmd.ins_entry.price));
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_ent
		always_ff @(posedge clk) begin
			if (cmd.pop) begin
				if (k < DEPTH - 1) begin
					ent_q[k] <= ent_q[(k + 1) % DEPTH];
				end
			end else if (cmd.dec) begin
				if (k == 0) begin
					ent_q[k].qty <= ent_q[k].qty - cmd.amt;
				end
			end else if (cmd.ins && !keep[k]) begin
				if (k == 0) begin
					ent_q[k] <= cmd.ins_entry;
				end else if (keep[(k + DEPTH - 1) % DEPTH]) begin
					ent_q[k] <= cmd.ins_entry;
				end else begin
					ent_q[k] <= ent_q[(k + DEPTH - 1) % DEPTH];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.ins) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign head = ent_q[0];
	assign count = cnt_q;
	assign full = (cnt_q == CW'(DEPTH));

endmodule

FILE: src/lobm_rpt.sv
// sorted report list: merge-insert with one shared adder, pop from head
module lobm_rpt #(
	parameter int unsigned DEPTH = 2 * lobm_pkg::BOOK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input lobm_pkg::rpt_cmd_t cmd,
	output lobm_pkg::rpt_entry_t head,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import lobm_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KW = TRADER_W + 1 + PRICE_W;

	rpt_entry_t ent_q [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [DEPTH-1:0] eq;
	logic [DEPTH-1:0] gt;
	logic [KW-1:0] new_key;
	logic [QTY_W-1:0] sel_qty;
	logic [QTY_W-1:0] sum;
	logic hit;

	assign new_key = {cmd.entry.trader, cmd.entry.side, cmd.entry.price};

	always_comb begin
		sel_qty = '0;
		for (int k = 0; k < DEPTH; k++) begin
			eq[k] = (CW'(k) < cnt_q) &&
				({ent_q[k].trader, ent_q[k].side, ent_q[k].price} == new_key);
			gt[k] = (CW'(k) < cnt_q) &&
				({ent_q[k].trader, ent_q[k].side, ent_q[k].price} > new_key);
			sel_qty = sel_qty | (eq[k] ? ent_q[k].qty : '0);
		end
	end

	assign hit = |eq;
	assign sum = sel_qty + cmd.entry.qty;

	for (genvar k = 0; k < DEPTH; k++) begin : g_ent
		always_ff @(posedge clk) begin
			if (cmd.pop) begin
				if (k < DEPTH - 1) begin
					ent_q[k] <= ent_q[(k + 1) % DEPTH];
				end
			end else if (cmd.ins) begin
				if (hit) begin
					if (eq[k]) begin
						ent_q[k].qty <= sum;
					end
				end else if (gt[k] || (CW'(k) == cnt_q)) begin
					if (k == 0) begin
						ent_q[k] <= cmd.entry;
					end else if (!gt[(k + DEPTH - 1) % DEPTH]) begin
						ent_q[k] <= cmd.entry;
					end else begin
						ent_q[k] <= ent_q[(k + DEPTH - 1) % DEPTH];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.ins && !hit) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign head = ent_q[0];
	assign count = cnt_q;

endmodule

FILE: src/limit_order_book_matcher_top.sv
// limit order book matcher top level: sequencer, books, report list, output register
//
// usage
// - ord channel takes one order item (trader, side, quantity, price); ready is high
//   only while the sequencer is idle, so one order is worked at a time
// - rpt channel gives the merged trade reports of that order, sorted by trader,
//   side (sell first) and price, then a status item if the remainder was dropped;
//   last marks the final item of the order
// - a zero quantity order is taken and gives nothing
// - steps per order: take it, then per match a head compare/update and two report
//   inserts, then the closing compare, resting, and emit of the result items,
//   which a stall on rpt can pause
// - the shared adder of the report list merges equal keys as reports are inserted
//   in sorted place, so no separate sort pass is needed
// - a registered output stage holds each result; a stalled receiver only pauses
//   the emit phase, no result is lost or repeated
// - reset clears both book counts and the report count; book contents are not
//   cleared and are only read below the count
module limit_order_book_matcher_top #(
	parameter int unsigned BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	lobm_ord_if.sink ord,
	lobm_rpt_if.source rpt
);
	import lobm_pkg::*;

	localparam int unsigned BCW = $clog2(BOOK_DEPTH + 1);
	localparam int unsigned RDEPTH = 2 * BOOK_DEPTH;
	localparam int unsigned RCW = $clog2(RDEPTH + 1);

	state_t state_q, state_nxt;

	// order registers
	logic [TRADER_W-1:0] trader_q;
	logic side_q;
	logic [QTY_W-1:0] qty_q;
	logic [PRICE_W-1:0] price_q;
	logic drop_q;
	// match registers
	logic [QTY_W-1:0] ov_q;
	logic [PRICE_W-1:0] mprice_q;
	logic [TRADER_W-1:0] ctr_q;

	book_cmd_t buy_cmd, sell_cmd;
	book_entry_t buy_head, sell_head, opp_head;
	logic [BCW-1:0] buy_cnt, sell_cnt, opp_cnt;
	logic buy_full, sell_full, own_full;

	rpt_cmd_t r_cmd;
	rpt_entry_t r_head;
	logic [RCW-1:0] r_cnt;

	logic o_valid_q;
	rpt_entry_t o_data_q;
	logic o_status_q, o_last_q, slot_free;

	logic accept, trade;
	logic [QTY_W-1:0] ov;
	book_cmd_t opp_cmd, own_cmd;

	assign accept = ord.valid && ord.ready;
	assign ord.ready = (state_q == S_IDLE);

	assign opp_head = side_q ? sell_head : buy_head;
	assign opp_cnt = side_q ? sell_cnt : buy_cnt;
	assign own_full = side_q ? buy_full : sell_full;

	// resting order acceptable to the aggressor
	assign trade = (opp_cnt != '0) && (qty_q != '0) &&
		(side_q ? (opp_head.price <= price_q) : (opp_head.price >= price_q));
	assign ov = (opp_head.qty < qty_q) ? opp_head.qty : qty_q;

	assign slot_free = !o_valid_q || rpt.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (ord.quantity != '0)) begin
					state_nxt = S_MATCH;
				end
			end
			S_MATCH: state_nxt = trade ? S_REP_AGG : S_REST;
			S_REP_AGG: state_nxt = S_REP_CTR;
			S_REP_CTR: state_nxt = S_MATCH;
			S_REST: begin
				if ((r_cnt == '0) && !((qty_q != '0) && own_full)) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (r_cnt == '0) begin
					if (!drop_q || slot_free) begin
						state_nxt = S_IDLE;
					end
				end else if (slot_free && (r_cnt == RCW'(1)) && !drop_q) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		opp_cmd = '0;
		own_cmd = '0;
		r_cmd = '0;
		own_cmd.ins_entry.trader = trader_q;
		own_cmd.ins_entry.price = price_q;
		own_cmd.ins_entry.qty = qty_q;
		opp_cmd.amt = ov;
		case (state_q)
			S_IDLE: r_cmd.clr = accept;
			S_MATCH: begin
				if (trade) begin
					opp_cmd.pop = (opp_head.qty == ov);
					opp_cmd.dec = (opp_head.qty != ov);
				end
			end
			S_REP_AGG: begin
				r_cmd.ins = 1'b1;
				r_cmd.entry.trader = trader_q;
				r_cmd.entry.side = side_q;
				r_cmd.entry.price = mprice_q;
				r_cmd.entry.qty = ov_q;
			end
			S_REP_CTR: begin
				r_cmd.ins = 1'b1;
				r_cmd.entry.trader = ctr_q;
				r_cmd.entry.side = !side_q;
				r_cmd.entry.price = mprice_q;
				r_cmd.entry.qty = ov_q;
			end
			S_REST: own_cmd.ins = (qty_q != '0) && !own_full;
			S_EMIT: r_cmd.pop = (r_cnt != '0) && slot_free;
			default: begin
			end
		endcase
		buy_cmd = side_q ? own_cmd : opp_cmd;
		sell_cmd = side_q ? opp_cmd : own_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drop_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE) begin
				drop_q <= 1'b0;
			end else if (state_q == S_REST) begin
				drop_q <= (qty_q != '0) && own_full;
			end
		end
	end

	// order and match payload
	always_ff @(posedge clk) begin
		if (accept) begin
			trader_q <= ord.trader;
			side_q <= ord.side;
			qty_q <= ord.quantity;
			price_q <= ord.price;
		end else if ((state_q == S_MATCH) && trade) begin
			qty_q <= qty_q - ov;
			ov_q <= ov;
			mprice_q <= opp_head.price;
			ctr_q <= opp_head.trader;
		end
	end

	lobm_book #(.DEPTH(BOOK_DEPTH)) u_buy (
		.clk(clk), .arst_n(arst_n), .desc(1'b1), .cmd(buy_cmd),
		.head(buy_head), .count(buy_cnt), .full(buy_full)
	);

	lobm_book #(.DEPTH(BOOK_DEPTH)) u_sell (
		.clk(clk), .arst_n(arst_n), .desc(1'b0), .cmd(sell_cmd),
		.head(sell_head), .count(sell_cnt), .full(sell_full)
	);

	lobm_rpt #(.DEPTH(RDEPTH)) u_rpt (
		.clk(clk), .arst_n(arst_n), .cmd(r_cmd), .head(r_head), .count(r_cnt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && slot_free && ((r_cnt != '0) || drop_q)) begin
			o_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && slot_free) begin
			if (r_cnt != '0) begin
				o_data_q <= r_head;
				o_status_q <= 1'b0;
				o_last_q <= (r_cnt == RCW'(1)) && !drop_q;
			end else if (drop_q) begin
				o_data_q.trader <= trader_q;
				o_data_q.side <= side_q;
				o_data_q.price <= price_q;
				o_data_q.qty <= qty_q;
				o_status_q <= 1'b1;
				o_last_q <= 1'b1;
			end
		end
	end

	assign rpt.valid = o_valid_q;
	assign rpt.trader_res = o_data_q.trader;
	assign rpt.side_res = o_data_q.side;
	assign rpt.quantity_res = o_data_q.qty;
	assign rpt.price_res = o_data_q.price;
	assign rpt.status = o_status_q;
	assign rpt.last = o_last_q;

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (r_cnt == '0))
		else $error("report list not empty while idle");
	a_book_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(buy_cnt <= BCW'(BOOK_DEPTH)) && (sell_cnt <= BCW'(BOOK_DEPTH)))
		else $error("book count beyond depth");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && drop_q) |-> own_full)
		else $error("remainder dropped with room in book");
	a_trade_seq: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MATCH) && trade) |=> (state_q == S_REP_AGG))
		else $error("match not followed by report insert");
`endif

endmodule
